[sv/bgm_pkg.sv]
`default_nettype none
package bgm_pkg;
  localparam int DivW = 33;

  typedef enum logic [2:0] {
    CS_UNKNOWN = 3'd0,
    CS_DISCHG  = 3'd1,
    CS_CHG     = 3'd2,
    CS_IDLE    = 3'd3,
    CS_FULL    = 3'd4
  } charge_state_t;

  typedef enum logic [1:0] {
    AL_NONE = 2'd0,
    AL_LOW  = 2'd1,
    AL_CRIT = 2'd2
  } alarm_t;

  typedef enum logic [1:0] {
    REG_LOW  = 2'd0,
    REG_CRIT = 2'd1,
    REG_VLIM = 2'd2,
    REG_VFB  = 2'd3
  } reg_idx_t;

  // datapath operation codes
  typedef enum logic [3:0] {
    OP_LOAD  = 4'd0,
    OP_CAP   = 4'd1,
    OP_REM   = 4'd2,
    OP_CUR   = 4'd3,
    OP_PCT   = 4'd4,
    OP_TIME  = 4'd5,
    OP_HLTH  = 4'd6,
    OP_FIN   = 4'd7,
    OP_IDLE  = 4'd8,
    OP_POST  = 4'd9
  } dp_op_t;

  typedef struct packed {
    logic   start;   // begin a division with the selected operands
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic reject;
  } dp_stat_t;

  typedef struct packed {
    logic        present_bit;
    logic        state_ok;
    logic [1:0]  state_code;
    logic        rate_ok;
    logic [15:0] rate_mw;
    logic        core_ok;
    logic [15:0] energy_mwh;
    logic [15:0] pack_mv;
    logic [15:0] design_mwh;
    logic        full_ok;
    logic [15:0] full_mwh;
  } in_item_t;

  typedef struct packed {
    logic        battery_present;
    logic [2:0]  charge_state;
    logic [6:0]  charge_percent;
    logic [25:0] design_mah;
    logic [25:0] charge_mah;
    logic [26:0] pack_ma;
    logic [15:0] minutes_to_empty;
    logic [15:0] minutes_to_full;
    logic [6:0]  health_percent;
    logic [1:0]  alarm;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  low_threshold;
    logic [6:0]  critical_threshold;
    logic [15:0] voltage_limit;
    logic [15:0] fallback_voltage;
  } cfg_t;
endpackage
`default_nettype wire

[sv/bgm_if.sv]
`default_nettype none
interface bgm_in_if;
  logic            valid;
  logic            ready;
  bgm_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bgm_out_if;
  logic             valid;
  logic             ready;
  bgm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/bgm_div.sv]
`default_nettype none
// restoring divider, one quotient bit per cycle; quotient 0 on zero divisor
module bgm_div (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [bgm_pkg::DivW-1:0] num,
  input  wire logic [bgm_pkg::DivW-1:0] den,
  output logic                         busy,
  output logic                         done,
  output logic [bgm_pkg::DivW-1:0]     quo
);
  import bgm_pkg::*;
  localparam int CntW = $clog2(DivW + 1);

  logic [DivW-1:0] q_r, q_nxt, d_r, d_nxt;
  logic [DivW:0]   rem_r, rem_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt, done_r, done_nxt, dz_r, dz_nxt;
  logic [DivW:0]   trial;

  always_comb begin
    q_nxt = q_r; d_nxt = d_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0; dz_nxt = dz_r;
    trial = {rem_r[DivW-1:0], q_r[DivW-1]};
    if (start) begin
      q_nxt = num; d_nxt = den; rem_nxt = '0;
      cnt_nxt = CntW'(DivW); busy_nxt = 1'b1; dz_nxt = (den == '0);
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt = {q_r[DivW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[DivW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0; dz_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt; dz_r <= dz_nxt;
    end
    q_r <= q_nxt; d_r <= d_nxt; rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = dz_r ? '0 : q_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without busy");
  a_no_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    !(done_r && busy_r && !$past(start))) else $error("busy and done overlap");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == '0) else $error("counter left running");
endmodule
`default_nettype wire

[sv/bgm_datapath.sv]
`default_nettype none
module bgm_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bgm_pkg::dp_cmd_t   cmd,
  output bgm_pkg::dp_stat_t       stat,
  input  wire bgm_pkg::in_item_t  in_item,
  input  wire bgm_pkg::cfg_t      cfg,
  output bgm_pkg::out_item_t      res
);
  import bgm_pkg::*;

  in_item_t        it_r;
  logic [15:0]     v_r;
  logic [25:0]     cap_r, rem_r, cur_r;
  logic [6:0]      pct_r, hl_r, last_r;
  logic [16:0]     tte_r, ttf_r;
  logic [2:0]      st_r;
  logic [1:0]      al_r;
  logic            tsel_r;

  logic [DivW-1:0] num, den, quo;
  logic            dbusy, ddone;
  logic [25:0]     fill;
  logic            use_full;
  logic [2:0]      st_base;

  assign use_full = it_r.full_ok && (it_r.full_mwh != 16'd0);
  assign fill = (cap_r > rem_r) ? cap_r - rem_r : 26'd0;

  always_comb begin
    num = '0; den = '0;
    case (cmd.op)
      OP_CAP:  begin num = DivW'(it_r.design_mwh * 26'd1000); den = DivW'(v_r); end
      OP_REM:  begin num = DivW'(it_r.energy_mwh * 26'd1000); den = DivW'(v_r); end
      OP_CUR:  begin num = DivW'(it_r.rate_mw * 26'd1000);    den = DivW'(v_r); end
      OP_PCT:  begin
        if (use_full) begin
          num = DivW'(it_r.energy_mwh * 23'd100); den = DivW'(it_r.full_mwh);
        end else begin
          num = DivW'(rem_r * 33'd100); den = DivW'(cap_r);
        end
      end
      OP_TIME: begin
        num = tsel_r ? DivW'(fill * 32'd60) : DivW'(rem_r * 32'd60);
        den = DivW'(cur_r);
      end
      OP_HLTH: begin num = DivW'(it_r.full_mwh * 23'd100); den = DivW'(it_r.design_mwh); end
      default: ;
    endcase
  end

  bgm_div u_div (.clk, .rst_n, .start(cmd.start), .num, .den,
                 .busy(dbusy), .done(ddone), .quo);

  always_comb begin
    if (!it_r.state_ok) st_base = CS_UNKNOWN;
    else if (it_r.state_code == 2'd1) st_base = CS_DISCHG;
    else if (it_r.state_code == 2'd2) st_base = CS_CHG;
    else st_base = CS_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else if (cmd.op == OP_POST) begin
      last_r <= pct_r;
    end
    if (cmd.op == OP_LOAD) begin
      it_r <= in_item;
      v_r <= (in_item.pack_mv != 16'd0) ? in_item.pack_mv : cfg.fallback_voltage;
      tte_r <= '0; ttf_r <= '0; hl_r <= '0; cur_r <= '0; pct_r <= '0; al_r <= AL_NONE;
    end
    if (ddone) begin
      case (cmd.op)
        OP_CAP: cap_r <= quo[25:0];
        OP_REM: rem_r <= quo[25:0];
        OP_CUR: cur_r <= it_r.rate_ok ? quo[25:0] : 26'd0;
        OP_PCT: pct_r <= (quo > DivW'(100)) ? 7'd100 : quo[6:0];
        OP_TIME: begin
          if (tsel_r) ttf_r <= (quo > DivW'(65535)) ? 17'd65535 : quo[16:0];
          else        tte_r <= (quo > DivW'(65535)) ? 17'd65535 : quo[16:0];
        end
        OP_HLTH: hl_r <= (quo > DivW'(100)) ? 7'd100 : quo[6:0];
        default: ;
      endcase
    end
    if (cmd.op == OP_CUR && cmd.start) begin
      st_r <= st_base;
    end
    if (cmd.op == OP_PCT && cmd.start) begin
      tsel_r <= (st_r == CS_CHG);
    end
    if (cmd.op == OP_FIN) begin
      if (pct_r >= 7'd100 && st_r != CS_DISCHG) st_r <= CS_FULL;
      if (pct_r <= cfg.critical_threshold && last_r > cfg.critical_threshold)
        al_r <= AL_CRIT;
      else if (pct_r <= cfg.low_threshold && last_r > cfg.low_threshold)
        al_r <= AL_LOW;
      if (!use_full || it_r.design_mwh == 16'd0) hl_r <= '0;
      if (cur_r == 26'd0 || !(st_r == CS_DISCHG)) tte_r <= '0;
      // a full pack is no longer charging
      if (cur_r == 26'd0 || !(st_r == CS_CHG) || pct_r >= 7'd100) ttf_r <= '0;
    end
  end

  assign stat.div_busy = dbusy;
  assign stat.div_done = ddone;
  assign stat.reject = !it_r.present_bit || !it_r.core_ok ||
                       (it_r.pack_mv > cfg.voltage_limit) ||
                       (it_r.design_mwh == 16'hFFFF) || (it_r.energy_mwh == 16'hFFFF);

  always_comb begin
    res.battery_present  = 1'b1;
    res.charge_state     = st_r;
    res.charge_percent   = pct_r;
    res.design_mah       = cap_r;
    res.charge_mah       = rem_r;
    res.pack_ma          = (st_r == CS_DISCHG) ? 27'(-{1'b0, cur_r}) : {1'b0, cur_r};
    res.minutes_to_empty = tte_r[15:0];
    res.minutes_to_full  = ttf_r[15:0];
    res.health_percent   = hl_r;
    res.alarm            = al_r;
  end
endmodule
`default_nettype wire

[sv/bgm_ctrl.sv]
`default_nettype none
module bgm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_zero,
  output logic                  out_load,
  output bgm_pkg::dp_cmd_t      cmd,
  input  wire bgm_pkg::dp_stat_t stat
);
  import bgm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_CAP, S_REM, S_CUR, S_PCT, S_TIME, S_HLTH, S_FIN, S_FIN2, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   go_r, go_nxt, ov_r, ov_nxt, zero_r, zero_nxt;

  function automatic dp_op_t op_of(state_t s);
    unique case (s)
      S_CAP:  return OP_CAP;
      S_REM:  return OP_REM;
      S_CUR:  return OP_CUR;
      S_PCT:  return OP_PCT;
      S_TIME: return OP_TIME;
      S_HLTH: return OP_HLTH;
      S_FIN:  return OP_FIN;
      S_FIN2: return OP_POST;
      default: return OP_IDLE;
    endcase
  endfunction

  assign in_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_OUT) && (!ov_r || out_ready);

  always_comb begin
    state_nxt = state_r; go_nxt = 1'b0; ov_nxt = ov_r; zero_nxt = zero_r;
    cmd.op = op_of(state_r);
    cmd.start = go_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.op = OP_LOAD;
        if (in_valid && in_ready) state_nxt = S_CHECK;
        else cmd.op = OP_IDLE;
      end
      S_CHECK: begin
        if (stat.reject) begin
          zero_nxt = 1'b1; state_nxt = S_OUT;
        end else begin
          zero_nxt = 1'b0; state_nxt = S_CAP; go_nxt = 1'b1;
        end
      end
      S_CAP, S_REM, S_CUR, S_PCT, S_TIME, S_HLTH: begin
        if (stat.div_done) begin
          state_nxt = state_t'(state_r + 1'b1);
          go_nxt = (state_r != S_HLTH);
        end
      end
      S_FIN:  state_nxt = S_FIN2;
      S_FIN2: state_nxt = S_OUT;
      S_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; go_r <= 1'b0; ov_r <= 1'b0; zero_r <= 1'b0;
    end else begin
      state_r <= state_nxt; go_r <= go_nxt; ov_r <= ov_nxt; zero_r <= zero_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_zero  = zero_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("accept while busy");
  a_start_ok: assert property (@(posedge clk) disable iff (!rst_n)
    go_r |-> !stat.div_busy) else $error("start while divider busy");
  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && state_nxt == S_IDLE) |=> ov_r) else $error("result lost");
endmodule
`default_nettype wire

[sv/battery_gauge_metrics.sv]
`default_nettype none
// Battery gauge metrics: one snapshot item in, one result item out. A valid
// snapshot is checked, then six divisions (capacity, remaining, current,
// percent, time, health) share one 33-step restoring divider, and the finish
// states S_FIN and S_FIN2 run before its result is posted; the next item is
// accepted only after that. A rejected snapshot posts an all-zero result
// straight after the check. The next item is taken while the previous result
// waits in the output register; a finished result then waits until that
// register is free.
// Registers: 0x0 low threshold, 0x4 critical threshold, 0x8 voltage limit,
// 0xC fallback voltage.
module battery_gauge_metrics (
  input  wire logic        clk,
  input  wire logic        rst_n,
  bgm_in_if.sink           in_ch,
  bgm_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import bgm_pkg::*;

  cfg_t      cfg_r;
  dp_cmd_t   cmd;
  dp_stat_t  stat;
  out_item_t res, out_r;
  logic      ov, zero, wr, out_ld;
  reg_idx_t  idx;

  assign cfg_pready = 1'b1;
  assign idx = reg_idx_t'(cfg_paddr[3:2]);
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_threshold      <= 7'd10;
      cfg_r.critical_threshold <= 7'd5;
      cfg_r.voltage_limit      <= 16'd30000;
      cfg_r.fallback_voltage   <= 16'd11100;
    end else if (wr) begin
      unique case (idx)
        REG_LOW:  cfg_r.low_threshold      <= cfg_pwdata[6:0];
        REG_CRIT: cfg_r.critical_threshold <= cfg_pwdata[6:0];
        REG_VLIM: cfg_r.voltage_limit      <= cfg_pwdata[15:0];
        REG_VFB:  cfg_r.fallback_voltage   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LOW:  cfg_prdata = {25'd0, cfg_r.low_threshold};
      REG_CRIT: cfg_prdata = {25'd0, cfg_r.critical_threshold};
      REG_VLIM: cfg_prdata = {16'd0, cfg_r.voltage_limit};
      REG_VFB:  cfg_prdata = {16'd0, cfg_r.fallback_voltage};
      default:  cfg_prdata = '0;
    endcase
  end

  bgm_ctrl u_ctrl (.clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
                   .out_valid(ov), .out_ready(out_ch.ready), .out_zero(zero),
                   .out_load(out_ld), .cmd, .stat);

  bgm_datapath u_dp (.clk, .rst_n, .cmd, .stat, .in_item(in_ch.data), .cfg(cfg_r), .res);

  // result latched when the controller posts it
  always_ff @(posedge clk) begin
    if (out_ld) out_r <= zero ? '0 : res;
  end

  assign out_ch.valid = ov;
  assign out_ch.data  = out_r;
endmodule
`default_nettype wire
